// ----- design/btma_pkg.sv -----
package btma_pkg;

  localparam int WORD_W    = 32;
  localparam int CFG_IDX_W = 4;
  localparam int COEF_N    = 8;
  localparam int COEF_IDX_W = 3;

  localparam logic [WORD_W-1:0] S32_MAX = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] S32_MIN = 32'h8000_0000;

  // matrix register indexes, in configuration port order
  typedef enum logic [COEF_IDX_W-1:0] {
    X_C11 = 3'd0,
    X_C12 = 3'd1,
    X_C21 = 3'd2,
    X_C22 = 3'd3,
    Y_C11 = 3'd4,
    Y_C12 = 3'd5,
    Y_C21 = 3'd6,
    Y_C22 = 3'd7
  } coef_idx_t;

  // particle as carried down the pipeline
  typedef struct packed {
    logic [WORD_W-1:0] gamma;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] px;
    logic [WORD_W-1:0] py;
  } item_t;

endpackage

// ----- design/btma_in_if.sv -----
interface btma_in_if;
  logic                           valid;
  logic                           ready;
  logic [btma_pkg::WORD_W-1:0]    gamma_in;
  logic signed [btma_pkg::WORD_W-1:0] x_in;
  logic signed [btma_pkg::WORD_W-1:0] y_in;
  logic signed [btma_pkg::WORD_W-1:0] px_in;
  logic signed [btma_pkg::WORD_W-1:0] py_in;

  modport source (output valid, gamma_in, x_in, y_in, px_in, py_in, input ready);
  modport sink   (input valid, gamma_in, x_in, y_in, px_in, py_in, output ready);
endinterface

// ----- design/btma_out_if.sv -----
interface btma_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [btma_pkg::WORD_W-1:0] x_out;
  logic signed [btma_pkg::WORD_W-1:0] y_out;
  logic signed [btma_pkg::WORD_W-1:0] px_out;
  logic signed [btma_pkg::WORD_W-1:0] py_out;
  logic                           gamma_zero;
  logic                           saturated;

  modport source (output valid, x_out, y_out, px_out, py_out, gamma_zero, saturated,
                  input ready);
  modport sink   (input valid, x_out, y_out, px_out, py_out, gamma_zero, saturated,
                  output ready);
endinterface

// ----- design/beam_transfer_matrix_apply_core.sv -----
// channel   | dir | handshake     | payload
// in_item   | in  | valid/ready   | gamma_in, x_in, y_in, px_in, py_in
// out_item  | out | valid/ready   | x_out, y_out, px_out, py_out, gamma_zero, saturated
// cfg_*     | in  | cfg_wr_en     | cfg_index, cfg_data (matrix coefficients)
//
// one item per clock while the output is not stalled; from accept to out_item.valid an
// item passes the input register, the restoring divider (one quotient bit per stage, 32+FRAC_BITS
// stages), then the clip, matrix multiply, sum, momentum multiply and output stages
// synchronous active-low reset clears valid bits and loads the identity matrices
// a stalled output freezes the whole pipeline; in_item.ready drops only while the
// output register holds an item that is not taken
module beam_transfer_matrix_apply_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  btma_in_if.sink                                in_item,
  btma_out_if.source                             out_item,
  input  logic                                   cfg_wr_en,
  input  logic [btma_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [btma_pkg::WORD_W-1:0]            cfg_data
);

  localparam int WW = btma_pkg::WORD_W;
  localparam int DW = WW + FRAC_BITS;     // dividend / quotient width
  localparam int PW = 2 * WW;             // product width
  localparam int SW = PW + 1;             // sum width
  localparam logic [WW-1:0] COEF_ONE = WW'(1) << FRAC_BITS;

  // saturate a wide signed value to 32 bits, flag in the top bit
  function automatic logic [WW:0] clip_wide(input logic signed [SW-1:0] v);
    logic [WW:0] r;
    if ((&v[SW-1:WW-1]) || !(|v[SW-1:WW-1])) begin
      r = {1'b0, v[WW-1:0]};
    end else if (v[SW-1]) begin
      r = {1'b1, btma_pkg::S32_MIN};
    end else begin
      r = {1'b1, btma_pkg::S32_MAX};
    end
    return r;
  endfunction

  // apply sign to the quotient magnitude and saturate
  function automatic logic [WW:0] clip_angle(input logic [DW-1:0] q, input logic neg);
    logic [WW:0] r;
    if (neg) begin
      if ((|q[DW-1:WW]) || (q[WW-1] && (|q[WW-2:0]))) begin
        r = {1'b1, btma_pkg::S32_MIN};
      end else begin
        r = {1'b0, ~q[WW-1:0] + WW'(1)};
      end
    end else if (|q[DW-1:WW-1]) begin
      r = {1'b1, btma_pkg::S32_MAX};
    end else begin
      r = {1'b0, q[WW-1:0]};
    end
    return r;
  endfunction

  // coefficient registers
  logic [WW-1:0] coef_r [btma_pkg::COEF_N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[btma_pkg::X_C11] <= COEF_ONE;
      coef_r[btma_pkg::X_C12] <= '0;
      coef_r[btma_pkg::X_C21] <= '0;
      coef_r[btma_pkg::X_C22] <= COEF_ONE;
      coef_r[btma_pkg::Y_C11] <= COEF_ONE;
      coef_r[btma_pkg::Y_C12] <= '0;
      coef_r[btma_pkg::Y_C21] <= '0;
      coef_r[btma_pkg::Y_C22] <= COEF_ONE;
    end else if (cfg_wr_en && !cfg_index[btma_pkg::CFG_IDX_W-1]) begin
      // indexes past the last coefficient are dropped
      coef_r[cfg_index[btma_pkg::COEF_IDX_W-1:0]] <= cfg_data;
    end
  end

  // global advance: everything moves unless the output item is held
  logic o_v_r;
  logic en;
  assign en = !o_v_r || out_item.ready;
  assign in_item.ready = en;

  // divider pipeline: element 0 is the input register
  logic                v_r    [DW+1];
  btma_pkg::item_t     it_r   [DW+1];
  logic                negx_r [DW+1];
  logic                negy_r [DW+1];
  logic [DW-1:0]       numx_r [DW+1];
  logic [DW-1:0]       numy_r [DW+1];
  logic [WW-1:0]       remx_r [DW+1];
  logic [WW-1:0]       remy_r [DW+1];
  logic [DW-1:0]       qx_r   [DW+1];
  logic [DW-1:0]       qy_r   [DW+1];

  logic [WW-1:0]       remx_nxt [DW];
  logic [WW-1:0]       remy_nxt [DW];
  logic [DW-1:0]       qx_nxt   [DW];
  logic [DW-1:0]       qy_nxt   [DW];

  logic [WW-1:0] absx, absy;
  assign absx = in_item.px_in[WW-1] ? (~in_item.px_in + WW'(1)) : in_item.px_in;
  assign absy = in_item.py_in[WW-1] ? (~in_item.py_in + WW'(1)) : in_item.py_in;

  // one restoring step per stage, per plane
  always_comb begin
    logic [WW:0] shx, shy;
    logic        gex, gey;
    for (int k = 0; k < DW; k++) begin
      shx = {remx_r[k], numx_r[k][DW-1]};
      shy = {remy_r[k], numy_r[k][DW-1]};
      gex = shx >= {1'b0, it_r[k].gamma};
      gey = shy >= {1'b0, it_r[k].gamma};
      remx_nxt[k] = gex ? WW'(shx - {1'b0, it_r[k].gamma}) : shx[WW-1:0];
      remy_nxt[k] = gey ? WW'(shy - {1'b0, it_r[k].gamma}) : shy[WW-1:0];
      qx_nxt[k]   = {qx_r[k][DW-2:0], gex};
      qy_nxt[k]   = {qy_r[k][DW-2:0], gey};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DW; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_item.valid;
      for (int k = 1; k <= DW; k++) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it_r[0]   <= '{gamma: in_item.gamma_in, x: in_item.x_in, y: in_item.y_in,
                     px: in_item.px_in, py: in_item.py_in};
      negx_r[0] <= in_item.px_in[WW-1];
      negy_r[0] <= in_item.py_in[WW-1];
      numx_r[0] <= {absx, {FRAC_BITS{1'b0}}};
      numy_r[0] <= {absy, {FRAC_BITS{1'b0}}};
      remx_r[0] <= '0;
      remy_r[0] <= '0;
      qx_r[0]   <= '0;
      qy_r[0]   <= '0;
      for (int k = 1; k <= DW; k++) begin
        it_r[k]   <= it_r[k-1];
        negx_r[k] <= negx_r[k-1];
        negy_r[k] <= negy_r[k-1];
        numx_r[k] <= numx_r[k-1] << 1;
        numy_r[k] <= numy_r[k-1] << 1;
        remx_r[k] <= remx_nxt[k-1];
        remy_r[k] <= remy_nxt[k-1];
        qx_r[k]   <= qx_nxt[k-1];
        qy_r[k]   <= qy_nxt[k-1];
      end
    end
  end

  // angle clip stage
  logic            a_v_r;
  btma_pkg::item_t a_it_r;
  logic [WW-1:0]   a_angx_r, a_angy_r;
  logic            a_sat_r;
  logic [WW:0]     cax, cay;
  assign cax = clip_angle(qx_r[DW], negx_r[DW]);
  assign cay = clip_angle(qy_r[DW], negy_r[DW]);

  // matrix product stage
  logic                  m_v_r;
  btma_pkg::item_t       m_it_r;
  logic                  m_sat_r;
  logic signed [PW-1:0]  m_pr_r [btma_pkg::COEF_N];

  // sum, floor shift and clip stage
  logic            s_v_r;
  btma_pkg::item_t s_it_r;
  logic            s_sat_r;
  logic [WW-1:0]   s_xn_r, s_yn_r, s_axn_r, s_ayn_r;
  logic signed [SW-1:0] sum [4];
  logic [WW:0]     cs [4];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      sum[j] = (SW'(m_pr_r[2*j]) + SW'(m_pr_r[2*j+1])) >>> FRAC_BITS;
      cs[j]  = clip_wide(sum[j]);
    end
  end

  // momentum multiply stage
  logic                 p_v_r;
  btma_pkg::item_t      p_it_r;
  logic                 p_sat_r;
  logic [WW-1:0]        p_xn_r, p_yn_r;
  logic signed [SW-1:0] p_mx_r, p_my_r;
  logic [WW:0]          cmx, cmy;
  assign cmx = clip_wide(p_mx_r >>> FRAC_BITS);
  assign cmy = clip_wide(p_my_r >>> FRAC_BITS);

  // output register
  logic [WW-1:0] o_x_r, o_y_r, o_px_r, o_py_r;
  logic          o_gz_r, o_sat_r;
  logic          gz;
  assign gz = (p_it_r.gamma == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      m_v_r <= 1'b0;
      s_v_r <= 1'b0;
      p_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= v_r[DW];
      m_v_r <= a_v_r;
      s_v_r <= m_v_r;
      p_v_r <= s_v_r;
      o_v_r <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_it_r   <= it_r[DW];
      a_angx_r <= cax[WW-1:0];
      a_angy_r <= cay[WW-1:0];
      a_sat_r  <= cax[WW] | cay[WW];

      m_it_r   <= a_it_r;
      m_sat_r  <= a_sat_r;
      m_pr_r[btma_pkg::X_C11] <= $signed(coef_r[btma_pkg::X_C11]) * $signed(a_it_r.x);
      m_pr_r[btma_pkg::X_C12] <= $signed(coef_r[btma_pkg::X_C12]) * $signed(a_angx_r);
      m_pr_r[btma_pkg::X_C21] <= $signed(coef_r[btma_pkg::X_C21]) * $signed(a_it_r.x);
      m_pr_r[btma_pkg::X_C22] <= $signed(coef_r[btma_pkg::X_C22]) * $signed(a_angx_r);
      m_pr_r[btma_pkg::Y_C11] <= $signed(coef_r[btma_pkg::Y_C11]) * $signed(a_it_r.y);
      m_pr_r[btma_pkg::Y_C12] <= $signed(coef_r[btma_pkg::Y_C12]) * $signed(a_angy_r);
      m_pr_r[btma_pkg::Y_C21] <= $signed(coef_r[btma_pkg::Y_C21]) * $signed(a_it_r.y);
      m_pr_r[btma_pkg::Y_C22] <= $signed(coef_r[btma_pkg::Y_C22]) * $signed(a_angy_r);

      s_it_r  <= m_it_r;
      s_xn_r  <= cs[0][WW-1:0];
      s_axn_r <= cs[1][WW-1:0];
      s_yn_r  <= cs[2][WW-1:0];
      s_ayn_r <= cs[3][WW-1:0];
      s_sat_r <= m_sat_r | cs[0][WW] | cs[1][WW] | cs[2][WW] | cs[3][WW];

      p_it_r  <= s_it_r;
      p_sat_r <= s_sat_r;
      p_xn_r  <= s_xn_r;
      p_yn_r  <= s_yn_r;
      p_mx_r  <= $signed(s_axn_r) * $signed({1'b0, s_it_r.gamma});
      p_my_r  <= $signed(s_ayn_r) * $signed({1'b0, s_it_r.gamma});

      // zero gamma passes the item through unchanged
      o_gz_r  <= gz;
      o_x_r   <= gz ? p_it_r.x  : p_xn_r;
      o_y_r   <= gz ? p_it_r.y  : p_yn_r;
      o_px_r  <= gz ? p_it_r.px : cmx[WW-1:0];
      o_py_r  <= gz ? p_it_r.py : cmy[WW-1:0];
      o_sat_r <= !gz && (p_sat_r | cmx[WW] | cmy[WW]);
    end
  end

  assign out_item.valid      = o_v_r;
  assign out_item.x_out      = o_x_r;
  assign out_item.y_out      = o_y_r;
  assign out_item.px_out     = o_px_r;
  assign out_item.py_out     = o_py_r;
  assign out_item.gamma_zero = o_gz_r;
  assign out_item.saturated  = o_sat_r;

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB        = 16;
  localparam int LATENCY   = FB + 37;
  localparam int IDLE_MAX  = 5000;
  localparam int HOLD_LEN  = 300;
  localparam int IDX_W     = btma_pkg::CFG_IDX_W;

  typedef logic signed [127:0] wide_t;

  localparam wide_t W32_MAX = 128'sd2147483647;
  localparam wide_t W32_MIN = -128'sd2147483648;
  localparam wide_t W64_MAX = 128'sd9223372036854775807;

  // one transported particle as it leaves the block
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] px;
    logic signed [31:0] py;
    bit                 gz;
    bit                 sat;
  } particle_t;

  // tracks the matrices and the particles still in flight
  class particle_tracker;
    logic signed [31:0] coef[btma_pkg::COEF_N];
    particle_t          in_flight[$];

    function void load_identity();
      foreach (coef[i]) coef[i] = 0;
      coef[btma_pkg::X_C11] = 32'sd65536;
      coef[btma_pkg::X_C22] = 32'sd65536;
      coef[btma_pkg::Y_C11] = 32'sd65536;
      coef[btma_pkg::Y_C22] = 32'sd65536;
    endfunction

    function void set_coef(int idx, logic [31:0] v);
      if (idx < btma_pkg::COEF_N) coef[idx] = v;
    endfunction

    function int pending();
      return in_flight.size();
    endfunction

    function logic signed [31:0] clip(wide_t v, ref bit sat);
      if (v > W32_MAX) begin
        sat = 1;
        return W32_MAX[31:0];
      end
      if (v < W32_MIN) begin
        sat = 1;
        return W32_MIN[31:0];
      end
      return v[31:0];
    endfunction

    // floor((a*b + c*d) / 2^FB), with the positive-overflow clamp
    function logic signed [31:0] dot(wide_t a, wide_t b, wide_t c, wide_t d, ref bit sat);
      wide_t p1, p2;
      p1 = a * b;
      p2 = c * d;
      if (p1 > 0 && p2 > 0 && p1 + p2 > W64_MAX) begin
        sat = 1;
        return W32_MAX[31:0];
      end
      return clip((p1 + p2) >>> FB, sat);
    endfunction

    function void transport(int base, logic signed [31:0] pos, logic signed [31:0] mom,
                            wide_t g, ref logic signed [31:0] pos_n,
                            ref logic signed [31:0] mom_n, ref bit sat);
      wide_t w_pos, w_mom, w_ang, w_angn;
      w_pos  = pos;
      w_mom  = mom;
      w_ang  = clip((w_mom <<< FB) / g, sat);
      pos_n  = dot(coef[base], w_pos, coef[base+1], w_ang, sat);
      w_angn = dot(coef[base+2], w_pos, coef[base+3], w_ang, sat);
      mom_n  = clip((w_angn * g) >>> FB, sat);
    endfunction

    function void note_particle(btma_pkg::item_t it);
      particle_t r;
      wide_t     g;
      g     = $signed({96'd0, it.gamma});
      r.gz  = (it.gamma == 0);
      r.sat = 0;
      if (r.gz) begin
        r.x  = it.x;
        r.y  = it.y;
        r.px = it.px;
        r.py = it.py;
      end else begin
        transport(btma_pkg::X_C11, it.x, it.px, g, r.x, r.px, r.sat);
        transport(btma_pkg::Y_C11, it.y, it.py, g, r.y, r.py, r.sat);
      end
      in_flight.insert(in_flight.size(), r);
    endfunction

    // empty string when the particle matches the oldest one in flight
    function string check_particle(particle_t got);
      particle_t e;
      string     msg;
      if (in_flight.size() == 0) return "result with no particle in flight";
      e   = in_flight.pop_front();
      msg = "";
      if (got.x !== e.x) msg = {msg, $sformatf(" x %h/%h", got.x, e.x)};
      if (got.y !== e.y) msg = {msg, $sformatf(" y %h/%h", got.y, e.y)};
      if (got.px !== e.px) msg = {msg, $sformatf(" px %h/%h", got.px, e.px)};
      if (got.py !== e.py) msg = {msg, $sformatf(" py %h/%h", got.py, e.py)};
      if (got.gz !== e.gz) msg = {msg, $sformatf(" gamma_zero %b/%b", got.gz, e.gz)};
      if (got.sat !== e.sat) msg = {msg, $sformatf(" saturated %b/%b", got.sat, e.sat)};
      return msg;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [btma_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [btma_pkg::WORD_W-1:0] cfg_data;

  btma_in_if  in_if();
  btma_out_if out_if();

  beam_transfer_matrix_apply_core #(.FRAC_BITS(FB)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_if),
    .out_item  (out_if),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  particle_tracker tracker = new();
  int errors;
  int idle_cycles;
  int burst_left;
  bit hold_req;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  task automatic report(string msg);
    $display("mismatch at %0t:%s", $realtime, msg);
    errors++;
  endtask

  // sample both channels at the edge; also the no-progress watchdog
  always @(posedge clk) begin
    particle_t got;
    string     msg;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        tracker.note_particle('{gamma: in_if.gamma_in, x: in_if.x_in, y: in_if.y_in,
                                px: in_if.px_in, py: in_if.py_in});
      end
      if (out_if.valid && out_if.ready) begin
        got.x   = out_if.x_out;
        got.y   = out_if.y_out;
        got.px  = out_if.px_out;
        got.py  = out_if.py_out;
        got.gz  = out_if.gamma_zero;
        got.sat = out_if.saturated;
        msg = tracker.check_particle(got);
        if (msg != "") report(msg);
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_MAX) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // receiver: stall pattern changes every so often, plus one long hold-off
  initial begin
    int mode;
    int span;
    int tick;
    out_if.ready = 1'b0;
    mode = 0;
    span = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 0;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(20, 250);
        end
        span--;
        tick++;
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= ($urandom_range(0, 1) == 1);
          2: out_if.ready <= (tick % 5 != 0);
          default: out_if.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // sender: bursts with random gaps
  task automatic send(btma_pkg::item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_if.valid    <= 1'b1;
    in_if.gamma_in <= it.gamma;
    in_if.x_in     <= it.x;
    in_if.y_in     <= it.y;
    in_if.px_in    <= it.px;
    in_if.py_in    <= it.py;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // stop offering and wait for the pipeline to empty
  task automatic drain();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // load both matrices; an out-of-range index goes in the middle and must be ignored
  task automatic load_matrices(logic [31:0] vals[btma_pkg::COEF_N]);
    btma_pkg::coef_idx_t idx;
    idx = idx.first();
    cfg_wr_en <= 1'b1;
    for (int i = 0; i < btma_pkg::COEF_N; i++) begin
      cfg_index <= IDX_W'(idx);
      cfg_data  <= vals[i];
      tracker.set_coef(int'(idx), vals[i]);
      @(posedge clk);
      if (i == 3) begin
        cfg_index <= IDX_W'($urandom_range(btma_pkg::COEF_N, 15));
        cfg_data  <= $urandom;
        @(posedge clk);
      end
      idx = idx.next();
    end
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0, 1: return $urandom;
      2: return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
      default: return 32'($urandom_range(0, 1 << 17)) - 32'(1 << 16);
    endcase
  endfunction

  function automatic btma_pkg::item_t rand_particle();
    btma_pkg::item_t it;
    case ($urandom_range(0, 9))
      0: it.gamma = '0;
      1, 2: it.gamma = $urandom;
      3: it.gamma = $urandom_range(1, 255);
      default: it.gamma = $urandom_range(1 << 15, 1 << 20);
    endcase
    it.x  = rand_coord();
    it.y  = rand_coord();
    it.px = rand_coord();
    it.py = rand_coord();
    return it;
  endfunction

  function automatic logic [31:0] rand_coef();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
  endfunction

  initial begin
    logic [31:0]     vals[btma_pkg::COEF_N];
    btma_pkg::item_t it;
    btma_pkg::item_t directed[$];
    errors      = 0;
    idle_cycles = 0;
    burst_left  = 0;
    hold_req    = 0;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_if.valid    = 1'b0;
    in_if.gamma_in = '0;
    in_if.x_in     = '0;
    in_if.y_in     = '0;
    in_if.px_in    = '0;
    in_if.py_in    = '0;
    tracker.load_identity();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: identity matrices, zero gamma, field extremes, tiny and huge gamma
    directed.insert(directed.size(),
                    '{32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
    directed.insert(directed.size(),
                    '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000});
    directed.insert(directed.size(),
                    '{32'h1_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                      32'h7fff_ffff});
    directed.insert(directed.size(), '{32'h1_0000, 32'h0, 32'h0, 32'h0, 32'h0});
    directed.insert(directed.size(),
                    '{32'h1, 32'h1_0000, 32'hffff_0000, 32'h7fff_ffff, 32'h8000_0000});
    directed.insert(directed.size(),
                    '{32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                      32'h8000_0000});
    directed.insert(directed.size(),
                    '{32'hffff_ffff, 32'h0, 32'h0, 32'hffff_ffff, 32'h1});
    directed.insert(directed.size(),
                    '{32'h2_0000, 32'h3_0000, 32'hfffd_0000, 32'hffff_ffff, 32'h1});
    foreach (directed[i]) send(directed[i]);
    drain();

    // all coefficients at the negative extreme: products hit the overflow clamp
    foreach (vals[i]) vals[i] = 32'h8000_0000;
    load_matrices(vals);
    directed.delete();
    directed.insert(directed.size(),
                    '{32'h1_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000});
    directed.insert(directed.size(),
                    '{32'h1_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                      32'h7fff_ffff});
    directed.insert(directed.size(),
                    '{32'hffff_ffff, 32'h1, 32'hffff_ffff, 32'h10, 32'hffff_fff0});
    directed.insert(directed.size(),
                    '{32'h0, 32'h1234_5678, 32'h9abc_def0, 32'h1, 32'hffff_ffff});
    foreach (directed[i]) send(directed[i]);
    drain();

    // positive extreme
    foreach (vals[i]) vals[i] = 32'h7fff_ffff;
    load_matrices(vals);
    foreach (directed[i]) send(directed[i]);
    send('{32'h1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
    drain();

    // zero matrices
    foreach (vals[i]) vals[i] = 32'h0;
    load_matrices(vals);
    foreach (directed[i]) send(directed[i]);
    drain();

    // random phases; one starts with a long receiver hold-off so the pipeline backs up
    for (int ph = 0; ph < 7; ph++) begin
      foreach (vals[i]) vals[i] = rand_coef();
      load_matrices(vals);
      if (ph == 2) hold_req = 1;
      repeat (155) begin
        it = rand_particle();
        send(it);
      end
      drain();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
